### hw/rtl/bmbd_pkg.sv
// ----------------------------------------------------------------------------
// bmbd_pkg
// Shared types and constants of the banked bus decoder: target codes, map
// codes, write case codes of the control area and address boundaries.
// ----------------------------------------------------------------------------
package bmbd_pkg;

	localparam int unsigned CpuAddrW  = 16;
	localparam int unsigned PhysAddrW = 18;
	localparam int unsigned RamTopW   = 19;
	localparam int unsigned RegIdxW   = 4;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned PaddrW    = 3;

	localparam logic [CpuAddrW-1:0] AddrDirectTop = 16'h1000;
	localparam logic [CpuAddrW-1:0] AddrIoBase    = 16'hF800;
	localparam logic [CpuAddrW-1:0] AddrVia2Base  = 16'hF880;
	localparam logic [CpuAddrW-1:0] AddrExpBase   = 16'hF900;
	localparam logic [CpuAddrW-1:0] AddrAciaBase  = 16'hF980;
	localparam logic [CpuAddrW-1:0] AddrRomBase   = 16'hFA00;

	localparam logic [PhysAddrW-1:0] PhysMask    = 18'h3FFFF;
	localparam logic [PhysAddrW-1:0] RomTopBase  = 18'h30000;
	localparam logic [ByteW-1:0]     ExpReadData = 8'hFF;
	localparam logic [ByteW-1:0]     AciaReadData = 8'h00;

	localparam logic [RamTopW-1:0] RamTopReset = 19'd131072;

	// register byte addresses
	localparam logic [PaddrW-1:0] RegAddrRamTop = 3'd0;

	typedef enum logic [2:0] {
		TGT_MEM   = 3'd0,
		TGT_VIA1  = 3'd1,
		TGT_VIA2  = 3'd2,
		TGT_LCD   = 3'd3,
		TGT_CONST = 3'd4,
		TGT_IGN   = 3'd5,
		TGT_DROP  = 3'd6,
		TGT_TEST  = 3'd7
	} target_t;

	typedef enum logic [1:0] {
		MAP_IDENT = 2'd0,
		MAP_BANKS = 2'd1,
		MAP_ROM   = 2'd2
	} map_t;

	// write cases of the control area, one per 128-byte slice
	localparam logic [3:0] WC_VIA1     = 4'd0;
	localparam logic [3:0] WC_VIA2     = 4'd1;
	localparam logic [3:0] WC_SEL_ROM  = 4'd4;
	localparam logic [3:0] WC_SEL_BANK = 4'd5;
	localparam logic [3:0] WC_SEL_ID   = 4'd6;
	localparam logic [3:0] WC_RESTORE  = 4'd7;
	localparam logic [3:0] WC_SAVE     = 4'd8;
	localparam logic [3:0] WC_TEST     = 4'd9;
	localparam logic [3:0] WC_BANK0    = 4'd10;
	localparam logic [3:0] WC_BANK1    = 4'd11;
	localparam logic [3:0] WC_BANK2    = 4'd12;
	localparam logic [3:0] WC_BANK3    = 4'd13;
	localparam logic [3:0] WC_ROMSLOT  = 4'd14;
	localparam logic [3:0] WC_LCD      = 4'd15;

endpackage

### hw/rtl/banked_mmu_bus_decoder.sv
// ----------------------------------------------------------------------------
// banked_mmu_bus_decoder
// Decodes one CPU bus beat per cycle unless stalled: address translation
// through the bank maps, I/O routing and control writes that change the map.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tdata: cpu_addr, wdata; tuser: func
//  m_*      out  m_tvalid / m_tready  tdata: mem_addr, reg_index, const_data,
//                                     out_data; tuser: target, mem_write
//  apb      in   psel / penable       ram_top at byte address 0
//
//  From acceptance to result a beat passes the input register, then decode
//  logic into the result register. One beat is accepted every cycle.
//  Map state changes as a beat leaves the input register, so the next beat
//  decodes under the new map. A stalled result holds both stages; s_tready
//  drops only while the result register is full and not taken.
//  Reset clears maps, offsets and both valid flags and sets ram_top to 128K.
//
module banked_mmu_bus_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] cpu_addr, [23:16] wdata
	input  logic [0:0]  s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [17:0] mem_addr, [21:18] reg_index,
	                               // [29:22] const_data, [37:30] out_data, zero
	output logic [3:0]  m_tuser,   // [2:0] target, [3] mem_write
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [bmbd_pkg::PaddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bmbd_pkg::*;

	// configuration and mapping state
	logic [RamTopW-1:0] ram_top_q;
	logic [ByteW-1:0]   bank_offset_q [4];
	logic [ByteW-1:0]   rom_slot1_q;
	map_t               cur_map_q;
	map_t               saved_map_q;

	// input stage
	logic                v_s1;
	logic                wr_s1;
	logic [CpuAddrW-1:0] addr_s1;
	logic [ByteW-1:0]    wdata_s1;

	// result stage
	logic                 v_s2;
	target_t              tgt_s2;
	logic [PhysAddrW-1:0] pa_s2;
	logic [RegIdxW-1:0]   reg_s2;
	logic                 mw_s2;
	logic [ByteW-1:0]     cd_s2;
	logic [ByteW-1:0]     od_s2;

	logic adv_s2, adv_s1, in_fire, cfg_wr;

	assign adv_s2   = !v_s2 || m_tready;
	assign adv_s1   = v_s1 && adv_s2;
	assign s_tready = !v_s1 || adv_s2;
	assign in_fire  = s_tvalid && s_tready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == RegAddrRamTop) ? {{(32-RamTopW){1'b0}}, ram_top_q} : 32'd0;

	// ---------------- decode ----------------
	logic [1:0]           win;
	logic [PhysAddrW-1:0] win_off;
	logic [PhysAddrW-1:0] xlat;
	logic [3:0]           wcase;
	logic                 ctl_wr;
	target_t              tgt_d;
	logic [PhysAddrW-1:0] pa_d;
	logic [RegIdxW-1:0]   reg_d;
	logic                 mw_d;
	logic [ByteW-1:0]     cd_d;

	assign win   = addr_s1[15:14];
	assign wcase = addr_s1[10:7];
	assign ctl_wr = wr_s1 && (addr_s1 >= AddrIoBase);

	always_comb begin
		unique case (cur_map_q)
			MAP_BANKS: win_off = {bank_offset_q[win], 10'd0};
			MAP_ROM: begin
				if (win == 2'd0)
					win_off = '0;
				else if (win == 2'd1)
					win_off = {rom_slot1_q, 10'd0};
				else
					win_off = RomTopBase;
			end
			default: win_off = '0;
		endcase
	end

	assign xlat = (win_off + {{(PhysAddrW-CpuAddrW){1'b0}}, addr_s1}) & PhysMask;

	always_comb begin
		tgt_d = TGT_IGN;
		pa_d  = '0;
		reg_d = '0;
		mw_d  = 1'b0;
		cd_d  = '0;
		if (!wr_s1) begin
			priority if (addr_s1 < AddrDirectTop) begin
				tgt_d = TGT_MEM;
				pa_d  = {{(PhysAddrW-CpuAddrW){1'b0}}, addr_s1};
			end else if (addr_s1 < AddrIoBase) begin
				tgt_d = TGT_MEM;
				pa_d  = xlat;
			end else if (addr_s1 >= AddrRomBase) begin
				tgt_d = TGT_MEM;
				pa_d  = {{(PhysAddrW-CpuAddrW){1'b0}}, addr_s1} | RomTopBase;
			end else if (addr_s1 >= AddrAciaBase) begin
				tgt_d = TGT_CONST;
				cd_d  = AciaReadData;
			end else if (addr_s1 >= AddrExpBase) begin
				tgt_d = TGT_CONST;
				cd_d  = ExpReadData;
			end else if (addr_s1 >= AddrVia2Base) begin
				tgt_d = TGT_VIA2;
				reg_d = addr_s1[3:0];
			end else begin
				tgt_d = TGT_VIA1;
				reg_d = addr_s1[3:0];
			end
		end else if (addr_s1 < AddrDirectTop) begin
			tgt_d = TGT_MEM;
			pa_d  = {{(PhysAddrW-CpuAddrW){1'b0}}, addr_s1};
			mw_d  = 1'b1;
		end else if (ctl_wr) begin
			unique case (wcase)
				WC_VIA1: begin
					tgt_d = TGT_VIA1;
					reg_d = addr_s1[3:0];
				end
				WC_VIA2: begin
					tgt_d = TGT_VIA2;
					reg_d = addr_s1[3:0];
				end
				WC_TEST: tgt_d = TGT_TEST;
				WC_LCD: begin
					tgt_d = TGT_LCD;
					reg_d = {2'b00, addr_s1[1:0]};
				end
				default: tgt_d = TGT_IGN;
			endcase
		end else begin
			pa_d = xlat;
			if ({1'b0, xlat} < ram_top_q) begin
				tgt_d = TGT_MEM;
				mw_d  = 1'b1;
			end else begin
				tgt_d = TGT_DROP;
			end
		end
	end

	// ---------------- state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_top_q        <= RamTopReset;
			bank_offset_q[0] <= '0;
			bank_offset_q[1] <= '0;
			bank_offset_q[2] <= '0;
			bank_offset_q[3] <= '0;
			rom_slot1_q      <= '0;
			cur_map_q        <= MAP_IDENT;
			saved_map_q      <= MAP_IDENT;
		end else begin
			if (cfg_wr && paddr == RegAddrRamTop)
				ram_top_q <= pwdata[RamTopW-1:0];
			// commit control writes as the beat leaves the input stage
			if (adv_s1 && ctl_wr) begin
				unique case (wcase)
					WC_SEL_ROM:  cur_map_q <= MAP_ROM;
					WC_SEL_BANK: cur_map_q <= MAP_BANKS;
					WC_SEL_ID:   cur_map_q <= MAP_IDENT;
					WC_RESTORE:  cur_map_q <= saved_map_q;
					WC_SAVE:     saved_map_q <= cur_map_q;
					WC_BANK0:    bank_offset_q[0] <= wdata_s1;
					WC_BANK1:    bank_offset_q[1] <= wdata_s1;
					WC_BANK2:    bank_offset_q[2] <= wdata_s1;
					WC_BANK3:    bank_offset_q[3] <= wdata_s1;
					WC_ROMSLOT:  rom_slot1_q <= wdata_s1;
					default: ;
				endcase
			end
		end
	end

	// ---------------- pipeline ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			wr_s1    <= s_tuser[0];
			addr_s1  <= s_tdata[15:0];
			wdata_s1 <= s_tdata[23:16];
		end
		if (adv_s1) begin
			tgt_s2 <= tgt_d;
			pa_s2  <= pa_d;
			reg_s2 <= reg_d;
			mw_s2  <= mw_d;
			cd_s2  <= cd_d;
			od_s2  <= wr_s1 ? wdata_s1 : '0;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {2'b00, od_s2, cd_s2, reg_s2, pa_s2};
	assign m_tuser  = {mw_s2, tgt_s2};

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while result stage can move");

	a_mw_is_mem: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == TGT_MEM))
		else $error("memory write flagged for non-memory target");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	a_map_frozen_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s2) |=> ($stable(cur_map_q) && $stable(saved_map_q)))
		else $error("map changed while beat held in input stage");
`endif

endmodule
